[src/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and codes shared by the contiguous frame allocator and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // Range compares in the cells: frame index plus a run of up to 63 frames, for up to 1024 frames
    localparam int RANGE_W = 11;

    localparam logic       MODE_ALLOC   = 1'b0;
    localparam logic       MODE_RELEASE = 1'b1;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [5:0] page_count;
        logic [4:0] release_start;
    } cfa_req_t;

    typedef struct packed {
        logic [4:0] start_frame;
        logic       failed;
    } cfa_rsp_t;

    // Per-cycle control broadcast to every frame cell
    typedef struct packed {
        logic               shift;
        logic               wr_en;
        logic               wr_val;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
    } cfa_cell_ctrl_t;

    // Control from the sequencer to the run tracker
    typedef struct packed {
        logic clr;
        logic step;
        logic used;
    } cfa_scan_ctrl_t;

endpackage

`default_nettype wire

[src/contiguous_frame_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// Bitmap allocator of contiguous page frames, first, best or worst fit.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_data): a word either allocates
// page_count contiguous frames or releases page_count frames from
// release_start. Response channel (rsp_valid / rsp_stall / rsp_data): one
// word per request, the start frame of the run or the failed flag.
// cfg_we / cfg_wdata write the placement rule; the user must write it only
// while the block is idle, as the block itself does not enforce this. An
// allocate rotates the used bits once around the ring of frame cells past
// the run tracker, one frame per cycle, then closes the last run, marks the
// chosen run and returns to idle. A release goes straight to the mark step
// and back to idle. The response sits in an output register; a new request
// is taken while it waits, but the next result holds in the mark step until
// the receiver drops rsp_stall. Reset marks every frame free and selects
// first fit.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_frame_allocator #(
    parameter int NUM_FRAMES = 32
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_stall,
    input  cfa_pkg::cfa_req_t req_data,
    output logic              rsp_valid,
    input  wire               rsp_stall,
    output cfa_pkg::cfa_rsp_t rsp_data,
    input  wire               cfg_we,
    input  wire [1:0]         cfg_wdata
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int LW = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [LW-1:0]           cnt_reg, cnt_next;
    logic [1:0]              policy_reg;
    cfa_pkg::cfa_req_t       req_reg;
    cfa_pkg::cfa_rsp_t       rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic                    accept;
    logic                    slot_free;
    logic                    done;
    logic                    alloc_ok;
    logic                    scan_end;
    logic [NUM_FRAMES-1:0]   used;
    logic                    have;
    logic [FW-1:0]           best_start;
    logic [cfa_pkg::RANGE_W-1:0] lo;
    cfa_pkg::cfa_cell_ctrl_t cell_ctrl;
    cfa_pkg::cfa_scan_ctrl_t scan_ctrl;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign done      = (state_reg == ST_APPLY) && slot_free;
    assign scan_end  = (cnt_reg == LW'(NUM_FRAMES));
    assign alloc_ok  = (req_reg.page_count != 6'd0) && have;

    // Ring of frame cells
    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        cfa_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (used[(i + 1) % NUM_FRAMES]),
            .used     (used[i])
        );
    end

    cfa_scan #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .frame      (cnt_reg[FW-1:0]),
        .need       (req_reg.page_count),
        .policy     (policy_reg),
        .have       (have),
        .best_start (best_start)
    );

    always_comb
    begin
        lo = (req_reg.mode == cfa_pkg::MODE_RELEASE)
             ? cfa_pkg::RANGE_W'(req_reg.release_start)
             : cfa_pkg::RANGE_W'(best_start);
        cell_ctrl.shift  = (state_reg == ST_SCAN) && !scan_end;
        cell_ctrl.wr_en  = done && ((req_reg.mode == cfa_pkg::MODE_RELEASE) || alloc_ok);
        cell_ctrl.wr_val = (req_reg.mode == cfa_pkg::MODE_ALLOC);
        cell_ctrl.lo     = lo;
        cell_ctrl.hi     = lo + cfa_pkg::RANGE_W'(req_reg.page_count);

        scan_ctrl.clr  = accept;
        scan_ctrl.step = (state_reg == ST_SCAN);
        // past the last frame counts as used to close the final run
        scan_ctrl.used = scan_end ? 1'b1 : used[0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = (req_data.mode == cfa_pkg::MODE_RELEASE) ? ST_APPLY : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + LW'(1);
                if (scan_end)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (req_reg.mode == cfa_pkg::MODE_RELEASE)
                    begin
                        rsp_next.start_frame = 5'd0;
                        rsp_next.failed      = 1'b0;
                    end
                    else if (alloc_ok)
                    begin
                        rsp_next.start_frame = lo[4:0];
                        rsp_next.failed      = 1'b0;
                    end
                    else
                    begin
                        rsp_next.start_frame = 5'd0;
                        rsp_next.failed      = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            policy_reg    <= cfa_pkg::POLICY_FIRST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= req_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

[src/cfa_cell.sv]
// ----------------------------------------------------------------------------
// cfa_cell
// One frame of the used map: rotates with its neighbors during a scan and
// sets or clears itself when its index falls inside the applied run.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_cell #(
    parameter int IDX = 0
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  cfa_pkg::cfa_cell_ctrl_t ctrl,
    input  wire                    shift_in,
    output logic                   used
);

    localparam logic [cfa_pkg::RANGE_W-1:0] IDX_R = cfa_pkg::RANGE_W'(IDX);

    logic used_reg;
    logic used_next;
    logic in_run;

    assign in_run = (IDX_R >= ctrl.lo) && (IDX_R < ctrl.hi);

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.shift)
        begin
            used_next = shift_in;
        end
        else if (ctrl.wr_en && in_run)
        begin
            used_next = ctrl.wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign used = used_reg;

endmodule

`default_nettype wire

[src/cfa_scan.sv]
// ----------------------------------------------------------------------------
// cfa_scan
// Run tracker: watches one frame per cycle at the head of the cell ring and
// keeps the best free run under the placement rule.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_scan #(
    parameter int NUM_FRAMES = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  cfa_pkg::cfa_scan_ctrl_t     ctrl,
    input  wire [$clog2(NUM_FRAMES)-1:0] frame,
    input  wire [5:0]                   need,
    input  wire [1:0]                   policy,
    output logic                        have,
    output logic [$clog2(NUM_FRAMES)-1:0] best_start
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int LW = $clog2(NUM_FRAMES + 1);
    localparam int CW = (LW > 6) ? LW + 1 : 7;

    logic [FW-1:0] run_start_reg, run_start_next;
    logic [LW-1:0] run_len_reg, run_len_next;
    logic [FW-1:0] best_start_reg, best_start_next;
    logic [LW-1:0] best_len_reg, best_len_next;
    logic          have_reg, have_next;
    logic          wins;
    logic          fits;

    assign fits = CW'(run_len_reg) >= CW'(need);

    always_comb
    begin
        priority if (!have_reg)
        begin
            wins = 1'b1;
        end
        else if (policy == cfa_pkg::POLICY_BEST)
        begin
            wins = run_len_reg < best_len_reg;
        end
        else if (policy == cfa_pkg::POLICY_WORST)
        begin
            wins = run_len_reg > best_len_reg;
        end
        else
        begin
            wins = 1'b0;
        end
    end

    always_comb
    begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        have_next       = have_reg;
        if (ctrl.clr)
        begin
            run_len_next = '0;
            have_next    = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (!ctrl.used)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = frame;
                end
                run_len_next = run_len_reg + LW'(1);
            end
            else
            begin
                // close the run; ties keep the earlier one
                if (fits && wins)
                begin
                    have_next       = 1'b1;
                    best_start_next = run_start_reg;
                    best_len_next   = run_len_reg;
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
            have_reg    <= 1'b0;
        end
        else
        begin
            run_len_reg <= run_len_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_start_reg  <= run_start_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
    end

    assign have       = have_reg;
    assign best_start = best_start_reg;

endmodule

`default_nettype wire

[test/tb_contiguous_frame_allocator.sv]
// ----------------------------------------------------------------------------
// tb_contiguous_frame_allocator
// Self-checking bench for the contiguous frame allocator. A queue of request
// words drives the request channel with random gaps, and a clocked monitor
// checks each response word against a bitmap predictor kept in the bench.
// Each placement rule is run against fragmented maps, with random response
// stalls and one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_contiguous_frame_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR        = 32;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_LEN  = 165;

    // Spare rule code, behaves as first fit
    localparam logic [1:0] POLICY_SPARE = 2'd3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    cfa_pkg::cfa_req_t req_data = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    cfa_pkg::cfa_rsp_t rsp_data;
    logic     cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = cfa_pkg::POLICY_FIRST;

    // Predictor state
    logic [NFR-1:0] used_map = '0;
    logic [1:0]     fit_rule = cfa_pkg::POLICY_FIRST;

    cfa_pkg::cfa_req_t req_backlog[$];
    cfa_pkg::cfa_rsp_t rsp_expected[$];

    int  err_cnt        = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  idle_cycles    = 0;
    bit  quiet          = 1'b0;
    bit  long_hold_req  = 1'b0;
    bit  long_hold_done = 1'b0;

    contiguous_frame_allocator #(
        .NUM_FRAMES(NFR)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request word to the bitmap and return the response it earns
    function automatic cfa_pkg::cfa_rsp_t frame_map_step(cfa_pkg::cfa_req_t w);
        cfa_pkg::cfa_rsp_t r;
        logic [1:0] rule;
        int         need;
        int         run_start;
        int         run_len;
        int         pick_start;
        int         pick_len;
        bit         have;
        bit         used;
        bit         wins;
        r          = '0;
        need       = int'(w.page_count);
        run_start  = 0;
        run_len    = 0;
        pick_start = 0;
        pick_len   = 0;
        have       = 1'b0;
        if (w.mode == cfa_pkg::MODE_RELEASE)
        begin
            for (int f = 0; f < need; f++)
                if (int'(w.release_start) + f < NFR)
                    used_map[int'(w.release_start) + f] = 1'b0;
            return r;
        end
        if (need == 0 || need > NFR)
        begin
            r.failed = 1'b1;
            return r;
        end
        rule = fit_rule;
        if (rule != cfa_pkg::POLICY_BEST && rule != cfa_pkg::POLICY_WORST)
            rule = cfa_pkg::POLICY_FIRST;
        // The step past the last frame closes the final run
        for (int f = 0; f <= NFR; f++)
        begin
            used = (f == NFR) ? 1'b1 : used_map[f];
            if (!used)
            begin
                if (run_len == 0)
                    run_start = f;
                run_len++;
            end
            else
            begin
                if (run_len >= need)
                begin
                    if (!have)
                        wins = 1'b1;
                    else if (rule == cfa_pkg::POLICY_BEST)
                        wins = run_len < pick_len;
                    else if (rule == cfa_pkg::POLICY_WORST)
                        wins = run_len > pick_len;
                    else
                        wins = 1'b0;
                    if (wins)
                    begin
                        have       = 1'b1;
                        pick_start = run_start;
                        pick_len   = run_len;
                        if (rule == cfa_pkg::POLICY_FIRST)
                            break;
                    end
                end
                run_len = 0;
            end
        end
        if (!have)
        begin
            r.failed = 1'b1;
            return r;
        end
        for (int f = pick_start; f < pick_start + need; f++)
            if (f < NFR)
                used_map[f] = 1'b1;
        r.start_frame = pick_start[4:0];
        return r;
    endfunction

    function automatic cfa_pkg::cfa_req_t make_word(logic m, int count, int start);
        cfa_pkg::cfa_req_t w;
        w.mode          = m;
        w.page_count    = count[5:0];
        w.release_start = start[4:0];
        return w;
    endfunction

    function automatic cfa_pkg::cfa_req_t random_word();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return make_word(cfa_pkg::MODE_ALLOC, $urandom_range(1, 6), $urandom_range(0, 31));
        if (k < 50)
            return make_word(cfa_pkg::MODE_ALLOC, $urandom_range(7, 32), $urandom_range(0, 31));
        if (k < 88)
            return make_word(cfa_pkg::MODE_RELEASE, $urandom_range(1, 8), $urandom_range(0, 31));
        if (k < 92)
            return make_word(cfa_pkg::MODE_RELEASE, $urandom_range(0, 63),
                             $urandom_range(0, 31));
        if (k < 95)
            return make_word(cfa_pkg::MODE_RELEASE, NFR, 0);
        return make_word(cfa_pkg::MODE_ALLOC, $urandom_range(0, 63), $urandom_range(0, 31));
    endfunction

    // Holes of 3, 6, 2 and 6 frames, so each placement rule picks a different one
    task automatic queue_fragmented_map();
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, NFR, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, NFR, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 3, 2));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 6, 8));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 2, 20));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 6, 26));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 2, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 6, 17));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 7, 5));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, NFR, 0));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || rsp_expected.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_fit_rule(logic [1:0] p);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fit_rule  = p;
        @(negedge clk);
    endtask

    // Request driver: hold the word while stalled, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                rsp_expected.push_back(frame_map_step(req_data));
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req_data  <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 17);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        cfa_pkg::cfa_rsp_t want;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $error("response word with nothing expected: start_frame %0d failed %0b",
                           rsp_data.start_frame, rsp_data.failed);
                    err_cnt++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp_data.start_frame !== want.start_frame)
                    begin
                        $error("start_frame: expected %0d, got %0d",
                               want.start_frame, rsp_data.start_frame);
                        err_cnt++;
                    end
                    if (rsp_data.failed !== want.failed)
                    begin
                        $error("failed: expected %0b, got %0b", want.failed, rsp_data.failed);
                        err_cnt++;
                    end
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_stall  <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0] rule_seq[6];
        rule_seq = '{cfa_pkg::POLICY_WORST, cfa_pkg::POLICY_BEST, POLICY_SPARE,
                     cfa_pkg::POLICY_FIRST, cfa_pkg::POLICY_BEST, cfa_pkg::POLICY_WORST};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First fit after reset: full map, zero and oversized counts, edge releases
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, NFR, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 1, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 63, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 0, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 33, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 63, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 5, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 3, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 0, 2));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 4, 20));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 2, 1));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 2, 21));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 10));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, 40, 28));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 24, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_RELEASE, NFR, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 31, 31));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 0));
        req_backlog.push_back(make_word(cfa_pkg::MODE_ALLOC, 1, 0));
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_fit_rule(rule_seq[ph]);
            if (ph == 5)
                quiet = 1'b1;
            queue_fragmented_map();
            for (int i = 0; i < PHASE_LEN; i++)
                req_backlog.push_back(random_word());
            // Back the block up behind a receiver that holds off
            if (ph == 1)
                long_hold_req = 1'b1;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[contiguous_frame_allocator.f]
src/cfa_pkg.sv
src/cfa_cell.sv
src/cfa_scan.sv
src/contiguous_frame_allocator.sv
test/tb_contiguous_frame_allocator.sv
